// ===== src/best_fit_extent_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit extent allocator.
// Each macro is empty when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_EXTENT_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFEA_ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("bfea check failed");
`define BFEA_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("bfea check failed");
`else
`define BFEA_ASSERT_IMPL(label, prop)
`define BFEA_ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== src/bfea_pkg.sv =====
// ----------------------------------------------------------------------------
// bfea_pkg
// Types, constants and control structs shared by the extent allocator.
// ----------------------------------------------------------------------------
package bfea_pkg;

  localparam int unsigned ENTRIES     = 512;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned GUARD_BYTES = 4096;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned PAGE_SH     = $clog2(PAGE_BYTES);
  localparam int unsigned LEN_W       = 31;
  localparam int unsigned SIZE_W      = 31;
  localparam int unsigned ADDR_W      = 64;
  // Totals are kept two bits wider than lengths to detect oversize.
  localparam int unsigned TOT_W       = 33;
  localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = 64'hFFFFFF8080000000;
  localparam logic [ADDR_W-1:0] WINDOW_END_RST  = 64'hFFFFFF80C0000000;
  localparam logic [TOT_W-1:0]  LEN_MAX = TOT_W'(33'h07FFFFFFF);

  typedef enum logic [0:0] {
    CFG_WINDOW_BASE = 1'b0,
    CFG_WINDOW_END  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_A,
    S_ALLOC_WR,
    S_SCAN_SLOT,
    S_SCAN_LOW,
    S_INSERT,
    S_SCAN_UP,
    S_MERGE_UP,
    S_RESULT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;          // capture input item
    logic scan_clear;    // restart scan counter and search results
    logic scan_step;     // advance scan by one slot
    logic scan_mode_a;   // best-fit search
    logic scan_mode_s;   // first invalid slot
    logic scan_mode_l;   // lower neighbor
    logic scan_mode_u;   // upper neighbor
    logic alloc_commit;  // write allocation result
    logic insert_commit; // add or extend lower
    logic merge_commit;  // absorb upper neighbor
    logic set_status;
    logic [1:0] status;
    logic out_load;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic oversize;
    logic scan_done;
    logic found;         // result of the last scan
    logic bump_ok;
  } sts_t;

endpackage

// ===== src/bfea_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfea_ctrl
// Sequencer: runs checks, slot scans and commits for one transaction.
// ----------------------------------------------------------------------------
module bfea_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bfea_pkg::sts_t  sts,
  output bfea_pkg::ctl_t  ctl
);
  import bfea_pkg::*;

  state_t state, state_next;
  logic   out_pend, out_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= out_pend_next;
    end
  end

  assign out_valid = out_pend;
  // A new transaction can enter as soon as the previous result is loaded.
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    ctl           = '0;
    out_pend_next = out_pend && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.scan_clear = 1'b1;
        if (sts.zero_req) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_IGNORED;
          state_next     = S_RESULT;
        end else if (sts.oversize) begin
          ctl.set_status = 1'b1;
          ctl.status     = sts.is_free ? ST_DROPPED : ST_NO_SPACE;
          state_next     = S_RESULT;
        end else begin
          state_next = sts.is_free ? S_SCAN_SLOT : S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        ctl.scan_step   = 1'b1;
        ctl.scan_mode_a = 1'b1;
        if (sts.scan_done) state_next = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        ctl.set_status = 1'b1;
        if (sts.found || sts.bump_ok) begin
          ctl.alloc_commit = 1'b1;
          ctl.status       = ST_DONE;
        end else begin
          ctl.status = ST_NO_SPACE;
        end
        state_next = S_RESULT;
      end
      S_SCAN_SLOT: begin
        ctl.scan_step   = 1'b1;
        ctl.scan_mode_s = 1'b1;
        if (sts.scan_done) begin
          ctl.scan_clear = 1'b1;
          if (sts.found) begin
            state_next = S_SCAN_LOW;
          end else begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_DROPPED;
            state_next     = S_RESULT;
          end
        end
      end
      S_SCAN_LOW: begin
        ctl.scan_step   = 1'b1;
        ctl.scan_mode_l = 1'b1;
        if (sts.scan_done) state_next = S_INSERT;
      end
      S_INSERT: begin
        ctl.insert_commit = 1'b1;
        ctl.scan_clear    = 1'b1;
        state_next        = S_SCAN_UP;
      end
      S_SCAN_UP: begin
        ctl.scan_step   = 1'b1;
        ctl.scan_mode_u = 1'b1;
        if (sts.scan_done) state_next = S_MERGE_UP;
      end
      S_MERGE_UP: begin
        ctl.merge_commit = 1'b1;
        ctl.set_status   = 1'b1;
        ctl.status       = ST_DONE;
        state_next       = S_RESULT;
      end
      S_RESULT: begin
        if (!out_pend || !out_stall) begin
          ctl.out_load  = 1'b1;
          out_pend_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/bfea_dp.sv =====
// ----------------------------------------------------------------------------
// bfea_dp
// Datapath: extent tables, valid bits, bump pointer and the slot scanner.
// ----------------------------------------------------------------------------
module bfea_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [63:0]           cfg_data,
  input  bfea_pkg::in_item_t    in_data,
  output bfea_pkg::out_item_t   out_data,
  input  bfea_pkg::ctl_t        ctl,
  output bfea_pkg::sts_t        sts
);
  import bfea_pkg::*;

  // Extent storage: one write port, one registered read port.
  logic [ADDR_W-1:0] base_mem [ENTRIES];
  logic [LEN_W-1:0]  len_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid;

  logic [ADDR_W-1:0] window_base, window_end, bump_next;
  logic              req_free;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;
  logic [TOT_W-1:0]  total;
  logic [ADDR_W-1:0] rng_base, rng_end;

  // Scan state: address counter, registered read pipeline.
  logic [CNT_W-1:0]  scan_cnt;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_base;
  logic [LEN_W-1:0]  rd_len;
  logic              rd_valid;

  logic              found;
  logic [IDX_W-1:0]  hit_idx;
  logic [ADDR_W-1:0] hit_base;
  logic [LEN_W-1:0]  hit_len;
  logic              slot_found;
  logic [IDX_W-1:0]  slot_idx;
  logic [LEN_W-1:0]  slot_len;
  logic [LEN_W-1:0]  ins_len;

  logic [1:0]        status;
  logic [ADDR_W-1:0] alloc_base;
  logic [ADDR_W-1:0] res_addr;

  // Total length in one register stage after capture.
  logic [TOT_W-1:0] pages_rounded;
  always_comb begin
    pages_rounded = ((TOT_W'(req_size) + TOT_W'(PAGE_BYTES - 1)) >> PAGE_SH) << PAGE_SH;
  end

  // The check cycle right after capture sees the new length directly.
  logic [TOT_W-1:0] total_comb;
  assign total_comb = pages_rounded + TOT_W'(2 * GUARD_BYTES);

  logic rd_hit;
  always_comb begin
    rd_hit = 1'b0;
    if (rd_vld && rd_valid) begin
      if (ctl.scan_mode_a) begin
        rd_hit = ({2'b0, rd_len} >= total) && (!found || rd_len < hit_len);
      end else if (ctl.scan_mode_l) begin
        rd_hit = !found && (rd_base + ADDR_W'(rd_len) == rng_base) &&
                 ({2'b0, rd_len} + total <= LEN_MAX);
      end else if (ctl.scan_mode_u) begin
        rd_hit = !found && (rd_idx != slot_idx) && (rd_base == rng_end) &&
                 ({2'b0, slot_len} + {2'b0, rd_len} <= LEN_MAX);
      end
    end
  end

  logic scan_end;
  assign scan_end = (scan_cnt == CNT_W'(ENTRIES)) && !rd_vld;

  logic bump_ok;
  assign bump_ok = !(bump_next > window_end) &&
                   !(ADDR_W'(total) > window_end - bump_next);

  assign sts.is_free   = req_free;
  assign sts.zero_req  = (req_size == '0) || (req_free && req_addr == '0);
  assign sts.oversize  = total_comb > LEN_MAX;
  assign sts.scan_done = scan_end;
  assign sts.found     = ctl.scan_mode_s ? (slot_found || (|(~valid))) : found;
  assign sts.bump_ok   = bump_ok;

  assign alloc_base = found ? hit_base : bump_next;
  assign ins_len    = found ? hit_len + LEN_W'(total) : LEN_W'(total);

  // First invalid slot via priority over the valid bits is a wide search;
  // it is instead resolved over the scan, one slot per cycle.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_free <= in_data.kind;
      req_size <= in_data.request_size;
      req_addr <= in_data.free_address;
    end
    total    <= total_comb;
    rng_base <= req_addr - ADDR_W'(GUARD_BYTES);
    rng_end  <= req_addr - ADDR_W'(GUARD_BYTES) + ADDR_W'(total);

    // Registered memory read.
    rd_base  <= base_mem[scan_cnt[IDX_W-1:0]];
    rd_len   <= len_mem[scan_cnt[IDX_W-1:0]];
    rd_valid <= valid[scan_cnt[IDX_W-1:0]];
    rd_idx   <= scan_cnt[IDX_W-1:0];

    if (ctl.scan_clear) begin
      found    <= 1'b0;
    end else if (rd_hit) begin
      found    <= 1'b1;
      hit_idx  <= rd_idx;
      hit_base <= rd_base;
      hit_len  <= rd_len;
    end

    if (ctl.scan_mode_s && rd_vld && !rd_valid && !slot_found) begin
      slot_idx <= rd_idx;
    end

    // The bump pointer moves on commit, so the address is kept here.
    if (ctl.alloc_commit) res_addr <= alloc_base + ADDR_W'(GUARD_BYTES);

    if (ctl.insert_commit) begin
      slot_len <= ins_len;
      if (found) slot_idx <= hit_idx;
      base_mem[found ? hit_idx : slot_idx] <= found ? hit_base : rng_base;
      len_mem[found ? hit_idx : slot_idx]  <= ins_len;
    end else if (ctl.merge_commit && found) begin
      len_mem[slot_idx] <= slot_len + hit_len;
    end else if (ctl.alloc_commit && found && hit_len != LEN_W'(total)) begin
      base_mem[hit_idx] <= hit_base + ADDR_W'(total);
      len_mem[hit_idx]  <= hit_len - LEN_W'(total);
    end

    if (ctl.set_status) status <= ctl.status;
    if (ctl.out_load) begin
      out_data.status <= status;
      out_data.result_address <= (status == ST_DONE && !req_free) ? res_addr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      scan_cnt    <= '0;
      rd_vld      <= 1'b0;
      slot_found  <= 1'b0;
      window_base <= WINDOW_BASE_RST;
      window_end  <= WINDOW_END_RST;
      bump_next   <= WINDOW_BASE_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_WINDOW_BASE: begin
            window_base <= cfg_data;
            bump_next   <= cfg_data;
          end
          CFG_WINDOW_END: window_end <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.scan_clear) begin
        scan_cnt <= '0;
        rd_vld   <= 1'b0;
        if (!ctl.scan_mode_s) slot_found <= 1'b0;
      end else if (ctl.scan_step) begin
        rd_vld <= scan_cnt != CNT_W'(ENTRIES);
        if (scan_cnt != CNT_W'(ENTRIES)) scan_cnt <= scan_cnt + 1'b1;
        if (ctl.scan_mode_s && rd_vld && !rd_valid) slot_found <= 1'b1;
      end
      if (ctl.alloc_commit) begin
        if (found) begin
          if (hit_len == LEN_W'(total)) valid[hit_idx] <= 1'b0;
        end else begin
          bump_next <= bump_next + ADDR_W'(total);
        end
      end
      if (ctl.insert_commit && !found) valid[slot_idx] <= 1'b1;
      if (ctl.merge_commit && found) valid[hit_idx] <= 1'b0;
    end
  end

endmodule

// ===== src/best_fit_extent_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_extent_allocator_top
// Best-fit address range allocator with free-extent coalescing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (kind, size, address)
//  out     | output    | out_valid/out_stall| out_data (address, status)
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// An allocate runs one best-fit sweep over the extent memory at one slot
// per cycle. A free runs up to three sweeps: free slot, lower neighbor,
// upper neighbor. Zero and oversized requests finish without a sweep.
// Reset is synchronous; it clears the valid bits and loads the window.
// The result register lets the next transaction start while out is stalled.
// ----------------------------------------------------------------------------
`include "best_fit_extent_allocator_top_defines.svh"

module best_fit_extent_allocator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bfea_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bfea_pkg::out_item_t  out_data,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data
);
  import bfea_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The sequencer owns the handshakes; the datapath owns all storage.
  bfea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  bfea_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Only one commit kind may fire in a cycle.
  `BFEA_ASSERT_IMPL(a_one_commit, $onehot0({ctl.alloc_commit, ctl.insert_commit, ctl.merge_commit}))
  // A result is loaded only when the output register is free to take it.
  `BFEA_ASSERT_IMPL(a_out_safe, ctl.out_load |-> (!out_valid || !out_stall))
  // A loaded transaction is followed by the check cycle.
  `BFEA_ASSERT_NEXT(a_load_stall, ctl.load, in_stall)

endmodule
